/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMPLY(lbl, ck, rn, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AST_NEXT(lbl, ck, rn, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
    else $error(msg);

`endif

/* rtl/bso_pkg.sv */
// Package: shift kinds, operation and carry codes for the shifter operand pipeline.
`timescale 1ns / 1ps
`default_nettype none
package bso_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AmtW   = 5;
  localparam int unsigned FieldW = 12;
  localparam int unsigned RsW    = 8;

  typedef enum logic [2:0] {
    K_LSL_IMM = 3'd0,
    K_LSL_REG = 3'd1,
    K_LSR_IMM = 3'd2,
    K_LSR_REG = 3'd3,
    K_ASR_IMM = 3'd4,
    K_ASR_REG = 3'd5,
    K_ROR_IMM = 3'd6,
    K_ROR_REG = 3'd7
  } shift_kind_t;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_LSL,
    OP_LSR,
    OP_ASR,
    OP_FILL,
    OP_ZERO,
    OP_RRX
  } op_t;

  typedef enum logic [1:0] {
    CY_CIN,
    CY_HI,
    CY_LO,
    CY_ZERO
  } cy_sel_t;

  typedef struct packed {
    op_t     op;
    cy_sel_t cy_sel;
    logic    cin;
    logic    sign;
  } ctl_t;

endpackage
`default_nettype wire

/* rtl/barrel_shifter_operand.sv */
// Top level: three-stage pipelined data-processing shifter operand and carry.
// Decode, rotate/mask and result stages are one register each.
// Throughput: one transfer per cycle while out_stall is low.
// A stall holds each full stage that has only full stages after it; empty stages keep filling behind them.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module barrel_shifter_operand (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_immediate_form,
  input  wire logic [bso_pkg::FieldW-1:0]   in_operand_field,
  input  wire logic [bso_pkg::WordW-1:0]    in_rm_value,
  input  wire logic [bso_pkg::RsW-1:0]      in_rs_value,
  input  wire logic                         in_carry_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [bso_pkg::WordW-1:0]         out_operand_value,
  output logic                              out_carry_out
);
  import bso_pkg::*;

  logic ready1, ready2, ready3;
  logic v1_r, v2_r, v3_r;

  // stage 1: decode
  logic [WordW-1:0] src_r, src_nxt;
  logic [AmtW-1:0]  amt_r, amt_nxt;
  logic [AmtW-1:0]  cnt_r, cnt_nxt;
  ctl_t             ctl1_r, ctl1_nxt;

  // stage 2: rotate and mask
  logic [WordW-1:0]   rot_r, rot_nxt;
  logic [WordW-1:0]   mask_r, mask_nxt;
  logic [2*WordW-1:0] dbl;
  ctl_t               ctl2_r;

  // stage 3: result
  logic [WordW-1:0] val_r, val_nxt;
  logic             cy_r, cy_nxt;

  shift_kind_t     kind;
  logic [AmtW-1:0] sh;

  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  assign kind = shift_kind_t'(in_operand_field[6:4]);
  assign sh   = in_operand_field[11:7];

  always_comb begin
    src_nxt         = in_rm_value;
    amt_nxt         = '0;
    cnt_nxt         = '0;
    ctl1_nxt.op     = OP_PASS;
    ctl1_nxt.cy_sel = CY_CIN;
    ctl1_nxt.cin    = in_carry_in;
    ctl1_nxt.sign   = in_rm_value[WordW-1];
    if (in_immediate_form) begin
      src_nxt = {{(WordW-8){1'b0}}, in_operand_field[7:0]};
      amt_nxt = {in_operand_field[11:8], 1'b0};
      ctl1_nxt.cy_sel = (in_operand_field[11:8] == 4'd0) ? CY_CIN : CY_HI;
    end else begin
      unique case (kind)
        K_LSL_IMM: begin
          if (sh != '0) begin
            amt_nxt = ~sh + AmtW'(1);
            cnt_nxt = sh;
            ctl1_nxt.op = OP_LSL;
            ctl1_nxt.cy_sel = CY_LO;
          end
        end
        K_LSL_REG: begin
          priority if (in_rs_value == '0) begin
            ctl1_nxt.op = OP_PASS;
          end else if (in_rs_value < RsW'(WordW)) begin
            amt_nxt = ~in_rs_value[AmtW-1:0] + AmtW'(1);
            cnt_nxt = in_rs_value[AmtW-1:0];
            ctl1_nxt.op = OP_LSL;
            ctl1_nxt.cy_sel = CY_LO;
          end else if (in_rs_value == RsW'(WordW)) begin
            ctl1_nxt.op = OP_ZERO;
            ctl1_nxt.cy_sel = CY_LO;
          end else begin
            ctl1_nxt.op = OP_ZERO;
            ctl1_nxt.cy_sel = CY_ZERO;
          end
        end
        K_LSR_IMM: begin
          ctl1_nxt.cy_sel = CY_HI;
          if (sh == '0) begin
            ctl1_nxt.op = OP_ZERO;
          end else begin
            amt_nxt = sh;
            cnt_nxt = sh;
            ctl1_nxt.op = OP_LSR;
          end
        end
        K_LSR_REG: begin
          priority if (in_rs_value == '0) begin
            ctl1_nxt.op = OP_PASS;
          end else if (in_rs_value < RsW'(WordW)) begin
            amt_nxt = in_rs_value[AmtW-1:0];
            cnt_nxt = in_rs_value[AmtW-1:0];
            ctl1_nxt.op = OP_LSR;
            ctl1_nxt.cy_sel = CY_HI;
          end else if (in_rs_value == RsW'(WordW)) begin
            ctl1_nxt.op = OP_ZERO;
            ctl1_nxt.cy_sel = CY_HI;
          end else begin
            ctl1_nxt.op = OP_ZERO;
            ctl1_nxt.cy_sel = CY_ZERO;
          end
        end
        K_ASR_IMM: begin
          ctl1_nxt.cy_sel = CY_HI;
          if (sh == '0) begin
            ctl1_nxt.op = OP_FILL;
          end else begin
            amt_nxt = sh;
            cnt_nxt = sh;
            ctl1_nxt.op = OP_ASR;
          end
        end
        K_ASR_REG: begin
          priority if (in_rs_value == '0) begin
            ctl1_nxt.op = OP_PASS;
          end else if (in_rs_value < RsW'(WordW)) begin
            amt_nxt = in_rs_value[AmtW-1:0];
            cnt_nxt = in_rs_value[AmtW-1:0];
            ctl1_nxt.op = OP_ASR;
            ctl1_nxt.cy_sel = CY_HI;
          end else begin
            ctl1_nxt.op = OP_FILL;
            ctl1_nxt.cy_sel = CY_HI;
          end
        end
        K_ROR_IMM: begin
          ctl1_nxt.cy_sel = CY_HI;
          if (sh == '0) begin
            amt_nxt = AmtW'(1);
            ctl1_nxt.op = OP_RRX;
          end else begin
            amt_nxt = sh;
          end
        end
        K_ROR_REG: begin
          if (in_rs_value != '0) begin
            amt_nxt = in_rs_value[AmtW-1:0];
            ctl1_nxt.cy_sel = CY_HI;
          end
        end
        default: begin
          ctl1_nxt.op = OP_PASS;
        end
      endcase
    end
  end

  assign dbl     = {src_r, src_r} >> amt_r;
  assign rot_nxt = dbl[WordW-1:0];

  always_comb begin
    if (ctl1_r.op == OP_LSL) begin
      mask_nxt = {WordW{1'b1}} << cnt_r;
    end else begin
      mask_nxt = {WordW{1'b1}} >> cnt_r;
    end
  end

  always_comb begin
    unique case (ctl2_r.op)
      OP_PASS: val_nxt = rot_r;
      OP_LSL:  val_nxt = rot_r & mask_r;
      OP_LSR:  val_nxt = rot_r & mask_r;
      OP_ASR:  val_nxt = (rot_r & mask_r) | ({WordW{ctl2_r.sign}} & ~mask_r);
      OP_FILL: val_nxt = {WordW{ctl2_r.sign}};
      OP_ZERO: val_nxt = '0;
      OP_RRX:  val_nxt = {ctl2_r.cin, rot_r[WordW-2:0]};
      default: val_nxt = rot_r;
    endcase
    unique case (ctl2_r.cy_sel)
      CY_CIN:  cy_nxt = ctl2_r.cin;
      CY_HI:   cy_nxt = rot_r[WordW-1];
      CY_LO:   cy_nxt = rot_r[0];
      CY_ZERO: cy_nxt = 1'b0;
      default: cy_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      src_r  <= src_nxt;
      amt_r  <= amt_nxt;
      cnt_r  <= cnt_nxt;
      ctl1_r <= ctl1_nxt;
    end
    if (ready2) begin
      rot_r  <= rot_nxt;
      mask_r <= mask_nxt;
      ctl2_r <= ctl1_r;
    end
    if (ready3) begin
      val_r <= val_nxt;
      cy_r  <= cy_nxt;
    end
  end

  assign out_valid         = v3_r;
  assign out_operand_value = val_r;
  assign out_carry_out     = cy_r;

  `AST_IMPLY(a_stall_only_full, clk, rst_n, in_stall, v1_r && v2_r && v3_r && out_stall, "early stall")
  `AST_NEXT(a_s1_advance, clk, rst_n, v1_r && ready2, v2_r, "stage 1 item lost on advance")
  `AST_NEXT(a_s2_hold, clk, rst_n, v2_r && !ready3, v2_r && $stable(rot_r) && $stable(ctl2_r), "stage 2 moved")

endmodule
`default_nettype wire
